### rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Sizes, stream layouts, microcode types and the microcode program.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS   = 12;
    localparam int RADIUS_BITS  = 11;
    localparam int PIX_BITS     = COORD_BITS + 2;
    localparam int COLOR_BITS   = 24;
    localparam int SQ_BITS      = 2 * RADIUS_BITS;
    localparam int X_BITS       = RADIUS_BITS + 1;
    localparam int SLOPE_BITS   = 36;
    localparam int DEC_BITS     = 48;
    localparam int MUL_BITS     = 24;
    localparam int PROD_BITS    = 2 * MUL_BITS;
    localparam int UPC_BITS     = 5;

    // Slave stream tdata layout, lowest field first.
    localparam int IN_CX_LSB     = 0;
    localparam int IN_CY_LSB     = IN_CX_LSB + COORD_BITS;
    localparam int IN_RX_LSB     = IN_CY_LSB + COORD_BITS;
    localparam int IN_RY_LSB     = IN_RX_LSB + RADIUS_BITS;
    localparam int IN_COLOR_LSB  = IN_RY_LSB + RADIUS_BITS;
    localparam int IN_USED_BITS  = IN_COLOR_LSB + COLOR_BITS;
    localparam int S_TDATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

    // Master stream tdata layout, lowest field first.
    localparam int OUT_USED_BITS = 2 * PIX_BITS + COLOR_BITS;
    localparam int M_TDATA_BITS  = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS    = M_TDATA_BITS - OUT_USED_BITS;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_REGION1 = 2'd1,
        PH_REGION2 = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LD_RXSQ,
        DP_LD_RYSQ,
        DP_INIT_DEC,
        DP_CHECK,
        DP_DEC_LOAD,
        DP_DEC_ADD,
        DP_DEC_SUB_END,
        DP_EMIT,
        DP_R1_UPD,
        DP_R1_DEC,
        DP_R2_UPD,
        DP_R2_DEC
    } dp_op_t;

    typedef enum logic [3:0] {
        MS_ZERO,
        MS_RX,
        MS_CUR_Y,
        MS_RXSQ,
        MS_RYSQ,
        MS_CUR_X,
        MS_X_PLUS1,
        MS_PROD,
        MS_Y_MINUS1
    } mul_sel_t;

    typedef enum logic [2:0] {
        JM_NEXT,
        JM_GOTO,
        JM_DISPATCH,
        JM_IF_LESS,
        JM_EMIT
    } jmp_t;

    typedef logic [UPC_BITS-1:0] upc_t;

    typedef struct packed {
        dp_op_t   dp_op;
        mul_sel_t mul_a;
        mul_sel_t mul_b;
        logic [1:0] quad;
        jmp_t     jmp;
        upc_t     target;
    } uword_t;

    typedef struct packed {
        logic   in_valid;
        logic   in_start;
        phase_t phase;
        logic   slope_less;
        logic   out_free;
    } useq_status_t;

    // Microcode addresses.
    localparam upc_t UA_IDLE = 5'd0;
    localparam upc_t UA_ST0  = 5'd1;
    localparam upc_t UA_ST1  = 5'd2;
    localparam upc_t UA_ST2  = 5'd3;
    localparam upc_t UA_ST3  = 5'd4;
    localparam upc_t UA_CHK  = 5'd5;
    localparam upc_t UA_SW0  = 5'd6;
    localparam upc_t UA_SW1  = 5'd7;
    localparam upc_t UA_SW2  = 5'd8;
    localparam upc_t UA_SW3  = 5'd9;
    localparam upc_t UA_SW4  = 5'd10;
    localparam upc_t UA_SW5  = 5'd11;
    localparam upc_t UA_EM0  = 5'd12;
    localparam upc_t UA_EM1  = 5'd13;
    localparam upc_t UA_EM2  = 5'd14;
    localparam upc_t UA_EM3  = 5'd15;
    localparam upc_t UA_R1A  = 5'd16;
    localparam upc_t UA_R1B  = 5'd17;
    localparam upc_t UA_R2A  = 5'd18;
    localparam upc_t UA_R2B  = 5'd19;

    // The microcode program. Each multiply issued in one step lands in the
    // product register and is consumed by the following step.
    function automatic uword_t ucode_word(input upc_t addr);
        uword_t w;
        begin
            w = '{dp_op: DP_NOP, mul_a: MS_ZERO, mul_b: MS_ZERO, quad: 2'd0,
                  jmp: JM_NEXT, target: UA_IDLE};
            unique case (addr)
                UA_IDLE: begin
                    w.jmp = JM_DISPATCH;
                end
                UA_ST0: begin
                    w.mul_a = MS_RX;
                    w.mul_b = MS_RX;
                end
                UA_ST1: begin
                    w.dp_op = DP_LD_RXSQ;
                    w.mul_a = MS_CUR_Y;
                    w.mul_b = MS_CUR_Y;
                end
                UA_ST2: begin
                    w.dp_op = DP_LD_RYSQ;
                    w.mul_a = MS_RXSQ;
                    w.mul_b = MS_CUR_Y;
                end
                UA_ST3: begin
                    w.dp_op = DP_INIT_DEC;
                end
                UA_CHK: begin
                    w.dp_op  = DP_CHECK;
                    w.jmp    = JM_IF_LESS;
                    w.target = UA_EM0;
                end
                UA_SW0: begin
                    w.mul_a = MS_CUR_X;
                    w.mul_b = MS_X_PLUS1;
                end
                UA_SW1: begin
                    w.mul_a = MS_RYSQ;
                    w.mul_b = MS_PROD;
                end
                UA_SW2: begin
                    w.dp_op = DP_DEC_LOAD;
                    w.mul_a = MS_Y_MINUS1;
                    w.mul_b = MS_Y_MINUS1;
                end
                UA_SW3: begin
                    w.mul_a = MS_RXSQ;
                    w.mul_b = MS_PROD;
                end
                UA_SW4: begin
                    w.dp_op = DP_DEC_ADD;
                    w.mul_a = MS_RYSQ;
                    w.mul_b = MS_RXSQ;
                end
                UA_SW5: begin
                    w.dp_op = DP_DEC_SUB_END;
                end
                UA_EM0: begin
                    w.dp_op  = DP_EMIT;
                    w.quad   = 2'd0;
                    w.jmp    = JM_EMIT;
                    w.target = UA_EM1;
                end
                UA_EM1: begin
                    w.dp_op  = DP_EMIT;
                    w.quad   = 2'd1;
                    w.jmp    = JM_EMIT;
                    w.target = UA_EM2;
                end
                UA_EM2: begin
                    w.dp_op  = DP_EMIT;
                    w.quad   = 2'd2;
                    w.jmp    = JM_EMIT;
                    w.target = UA_EM3;
                end
                UA_EM3: begin
                    w.dp_op  = DP_EMIT;
                    w.quad   = 2'd3;
                    w.jmp    = JM_EMIT;
                    w.target = UA_IDLE;
                end
                UA_R1A: begin
                    w.dp_op = DP_R1_UPD;
                end
                UA_R1B: begin
                    w.dp_op  = DP_R1_DEC;
                    w.jmp    = JM_GOTO;
                    w.target = UA_CHK;
                end
                UA_R2A: begin
                    w.dp_op = DP_R2_UPD;
                end
                UA_R2B: begin
                    w.dp_op  = DP_R2_DEC;
                    w.jmp    = JM_GOTO;
                    w.target = UA_EM0;
                end
                default: begin
                    w.jmp    = JM_GOTO;
                    w.target = UA_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

### rtl/mer_useq.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer microcode sequencer
// Step counter, program ROM and conditional jump logic.
// ----------------------------------------------------------------------------
module mer_useq
    import mer_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  useq_status_t status,
    output uword_t       uword
);

    upc_t pc_reg;
    upc_t pc_next;

    // Next step.
    always_comb
    begin
        pc_next = pc_reg;
        unique case (uword.jmp)
            JM_NEXT: begin
                pc_next = pc_reg + upc_t'(1);
            end
            JM_GOTO: begin
                pc_next = uword.target;
            end
            JM_DISPATCH: begin
                if (status.in_valid)
                begin
                    if (status.in_start)
                        pc_next = UA_ST0;
                    else if (status.phase == PH_REGION1)
                        pc_next = UA_R1A;
                    else if (status.phase == PH_REGION2)
                        pc_next = UA_R2A;
                    else
                        pc_next = UA_IDLE;
                end
            end
            JM_IF_LESS: begin
                pc_next = status.slope_less ? uword.target : pc_reg + upc_t'(1);
            end
            JM_EMIT: begin
                if (status.out_free)
                    pc_next = uword.target;
            end
            default: begin
                pc_next = UA_IDLE;
            end
        endcase
    end

    // Control word of the current step.
    always_comb
    begin
        uword = ucode_word(pc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= UA_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

### rtl/midpoint_ellipse_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer core
// Two-region midpoint ellipse walker run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                         Transaction
// s_axis    in   tvalid tready tdata tuser       one start or step command
// m_axis    out  tvalid tready tdata tlast tuser one mirrored pixel
//
// Flow: a transaction is taken only at the idle step of the program. A start
// runs the exact region one setup, and a command that leaves region one runs
// the exact region two setup. The single shared 24x24 multiplier sets the
// length of both setups, and the output register, loaded once per cycle while
// m_axis is free, paces the four mirrored pixels of each emitting command.
// Reset: rst_n clears the sequencer, the walker state and the output valid.
// Stalls: a stalled m_axis holds the program at its pixel step; the next
// command is taken while the last pixel still waits in the output register.
//
module midpoint_ellipse_rasterizer_core
    import mer_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // Fields from bit 0 up: center_x, center_y, radius_x, radius_y,
    // ink_color, zero fill.
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // Fields: operation (0 = start, 1 = step).
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, pixel_color, zero fill.
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,
    // Marks last_of_step.
    output logic                    m_axis_tlast,
    // Fields: ellipse_done.
    output logic                    m_axis_tuser
);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    uword_t       uword;
    useq_status_t status;

    logic s_fire;
    logic out_free;
    logic slope_less;

    // ------------------------------------------------------------------
    // Walker state
    // ------------------------------------------------------------------
    phase_t                 phase_reg,    phase_next;
    logic [X_BITS-1:0]      cur_x_reg,    cur_x_next;
    logic [RADIUS_BITS-1:0] cur_y_reg,    cur_y_next;
    logic [DEC_BITS-1:0]    decision_reg, decision_next;
    logic [SLOPE_BITS-1:0]  x_slope_reg,  x_slope_next;
    logic [SLOPE_BITS-1:0]  y_slope_reg,  y_slope_next;
    logic [SQ_BITS-1:0]     rx_sq_reg,    rx_sq_next;
    logic [SQ_BITS-1:0]     ry_sq_reg,    ry_sq_next;
    logic [COORD_BITS-1:0]  center_x_reg, center_x_next;
    logic [COORD_BITS-1:0]  center_y_reg, center_y_next;
    logic [COLOR_BITS-1:0]  color_reg,    color_next;

    // Datapath scratch registers.
    logic [RADIUS_BITS-1:0] radius_x_reg, radius_x_next;
    logic                   branch_reg,   branch_next;
    logic [PROD_BITS-1:0]   prod_reg,     prod_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [PIX_BITS-1:0]    out_x_reg,     out_x_next;
    logic [PIX_BITS-1:0]    out_y_reg,     out_y_next;
    logic [COLOR_BITS-1:0]  out_color_reg, out_color_next;
    logic                   out_last_reg,  out_last_next;
    logic                   out_done_reg,  out_done_next;

    // Multiplier operands.
    logic [MUL_BITS-1:0]    mul_a_val;
    logic [MUL_BITS-1:0]    mul_b_val;
    logic [X_BITS:0]        x_plus1;
    logic [RADIUS_BITS-1:0] y_minus1_abs;

    // Derived terms.
    logic [SLOPE_BITS-1:0]  rx_sq_dbl;
    logic [SLOPE_BITS-1:0]  ry_sq_dbl;
    logic [SQ_BITS:0]       rx_sq_round;
    logic                   load_pixel;

    assign s_axis_tready = (uword.jmp == JM_DISPATCH);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign slope_less    = (x_slope_reg < y_slope_reg);

    assign status = '{in_valid:   s_axis_tvalid,
                      in_start:   !s_axis_tuser,
                      phase:      phase_reg,
                      slope_less: slope_less,
                      out_free:   out_free};

    mer_useq u_useq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: one product per step, registered.
    // ------------------------------------------------------------------
    assign x_plus1      = {1'b0, cur_x_reg} + (X_BITS + 1)'(1);
    // |y - 1|, where y - 1 is minus one only when y is zero.
    assign y_minus1_abs = (cur_y_reg == '0) ? RADIUS_BITS'(1)
                                            : cur_y_reg - RADIUS_BITS'(1);

    always_comb
    begin
        case (uword.mul_a)
            MS_RX:       mul_a_val = MUL_BITS'(radius_x_reg);
            MS_CUR_Y:    mul_a_val = MUL_BITS'(cur_y_reg);
            MS_RXSQ:     mul_a_val = MUL_BITS'(rx_sq_reg);
            MS_RYSQ:     mul_a_val = MUL_BITS'(ry_sq_reg);
            MS_CUR_X:    mul_a_val = MUL_BITS'(cur_x_reg);
            MS_X_PLUS1:  mul_a_val = MUL_BITS'(x_plus1);
            MS_PROD:     mul_a_val = prod_reg[MUL_BITS-1:0];
            MS_Y_MINUS1: mul_a_val = MUL_BITS'(y_minus1_abs);
            default:     mul_a_val = '0;
        endcase
        case (uword.mul_b)
            MS_RX:       mul_b_val = MUL_BITS'(radius_x_reg);
            MS_CUR_Y:    mul_b_val = MUL_BITS'(cur_y_reg);
            MS_RXSQ:     mul_b_val = MUL_BITS'(rx_sq_reg);
            MS_RYSQ:     mul_b_val = MUL_BITS'(ry_sq_reg);
            MS_CUR_X:    mul_b_val = MUL_BITS'(cur_x_reg);
            MS_X_PLUS1:  mul_b_val = MUL_BITS'(x_plus1);
            MS_PROD:     mul_b_val = prod_reg[MUL_BITS-1:0];
            MS_Y_MINUS1: mul_b_val = MUL_BITS'(y_minus1_abs);
            default:     mul_b_val = '0;
        endcase
    end

    assign prod_next = mul_a_val * mul_b_val;

    assign rx_sq_dbl   = SLOPE_BITS'({rx_sq_reg, 1'b0});
    assign ry_sq_dbl   = SLOPE_BITS'({ry_sq_reg, 1'b0});
    assign rx_sq_round = {1'b0, rx_sq_reg} + (SQ_BITS + 1)'(2);

    // ------------------------------------------------------------------
    // Walker datapath. The decision term is kept as a two's complement
    // word; its sign is the top bit.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next    = phase_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        decision_next = decision_reg;
        x_slope_next  = x_slope_reg;
        y_slope_next  = y_slope_reg;
        rx_sq_next    = rx_sq_reg;
        ry_sq_next    = ry_sq_reg;
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        color_next    = color_reg;
        radius_x_next = radius_x_reg;
        branch_next   = branch_reg;

        if (s_fire)
        begin
            if (!s_axis_tuser)
            begin
                // A start drops whatever ellipse was in progress.
                center_x_next = s_axis_tdata[IN_CX_LSB +: COORD_BITS];
                center_y_next = s_axis_tdata[IN_CY_LSB +: COORD_BITS];
                radius_x_next = s_axis_tdata[IN_RX_LSB +: RADIUS_BITS];
                cur_y_next    = s_axis_tdata[IN_RY_LSB +: RADIUS_BITS];
                color_next    = s_axis_tdata[IN_COLOR_LSB +: COLOR_BITS];
                cur_x_next    = '0;
                x_slope_next  = '0;
            end
            else if (phase_reg != PH_REGION1 && phase_reg != PH_REGION2)
            begin
                phase_next = PH_IDLE;
            end
        end

        case (uword.dp_op)
            DP_LD_RXSQ: begin
                rx_sq_next = prod_reg[SQ_BITS-1:0];
            end
            DP_LD_RYSQ: begin
                ry_sq_next = prod_reg[SQ_BITS-1:0];
            end
            DP_INIT_DEC: begin
                // Region one starts at ry^2 + round(rx^2 / 4) - ry * rx^2.
                y_slope_next  = SLOPE_BITS'({prod_reg, 1'b0});
                decision_next = DEC_BITS'(ry_sq_reg)
                              + DEC_BITS'(rx_sq_round[SQ_BITS:2])
                              - prod_reg;
            end
            DP_CHECK: begin
                if (slope_less)
                    phase_next = PH_REGION1;
            end
            DP_DEC_LOAD: begin
                decision_next = prod_reg;
            end
            DP_DEC_ADD: begin
                decision_next = decision_reg + prod_reg;
            end
            DP_DEC_SUB_END: begin
                decision_next = decision_reg - prod_reg;
                phase_next    = (cur_y_reg != '0) ? PH_REGION2 : PH_IDLE;
            end
            DP_R1_UPD: begin
                branch_next  = !decision_reg[DEC_BITS-1];
                cur_x_next   = cur_x_reg + X_BITS'(1);
                x_slope_next = x_slope_reg + ry_sq_dbl;
                if (!decision_reg[DEC_BITS-1])
                begin
                    cur_y_next   = cur_y_reg - RADIUS_BITS'(1);
                    y_slope_next = y_slope_reg - rx_sq_dbl;
                end
            end
            DP_R1_DEC: begin
                decision_next = decision_reg + DEC_BITS'(ry_sq_reg)
                              + DEC_BITS'(x_slope_reg)
                              - (branch_reg ? DEC_BITS'(y_slope_reg) : '0);
            end
            DP_R2_UPD: begin
                branch_next  = decision_reg[DEC_BITS-1] || (decision_reg == '0);
                cur_y_next   = cur_y_reg - RADIUS_BITS'(1);
                y_slope_next = y_slope_reg - rx_sq_dbl;
                if (decision_reg[DEC_BITS-1] || (decision_reg == '0))
                begin
                    cur_x_next   = cur_x_reg + X_BITS'(1);
                    x_slope_next = x_slope_reg + ry_sq_dbl;
                end
            end
            DP_R2_DEC: begin
                decision_next = decision_reg + DEC_BITS'(rx_sq_reg)
                              - DEC_BITS'(y_slope_reg)
                              + (branch_reg ? DEC_BITS'(x_slope_reg) : '0);
                phase_next    = (cur_y_reg != '0) ? PH_REGION2 : PH_IDLE;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel output register. Quadrant bit 0 mirrors x, bit 1 mirrors y.
    // ------------------------------------------------------------------
    assign load_pixel = (uword.dp_op == DP_EMIT) && out_free;

    always_comb
    begin
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (load_pixel)
        begin
            out_valid_next = 1'b1;
            out_x_next     = uword.quad[0]
                           ? PIX_BITS'(center_x_reg) - PIX_BITS'(cur_x_reg)
                           : PIX_BITS'(center_x_reg) + PIX_BITS'(cur_x_reg);
            out_y_next     = uword.quad[1]
                           ? PIX_BITS'(center_y_reg) - PIX_BITS'(cur_y_reg)
                           : PIX_BITS'(center_y_reg) + PIX_BITS'(cur_y_reg);
            out_color_next = color_reg;
            out_last_next  = (uword.quad == 2'd3);
            out_done_next  = (uword.quad == 2'd3) && (phase_reg == PH_IDLE);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD_BITS{1'b0}}, out_color_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            decision_reg  <= '0;
            x_slope_reg   <= '0;
            y_slope_reg   <= '0;
            rx_sq_reg     <= '0;
            ry_sq_reg     <= '0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            decision_reg  <= decision_next;
            x_slope_reg   <= x_slope_next;
            y_slope_reg   <= y_slope_next;
            rx_sq_reg     <= rx_sq_next;
            ry_sq_reg     <= ry_sq_next;
            center_x_reg  <= center_x_next;
            center_y_reg  <= center_y_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radius_x_reg  <= radius_x_next;
        branch_reg    <= branch_next;
        prod_reg      <= prod_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // The finishing flag only ever rides on the fourth pixel of a command.
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("ellipse_done without last_of_step");

    // Between commands region two always has a row left to step.
    a_region2_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && phase_reg == PH_REGION2) |-> (cur_y_reg != '0))
        else $error("region two waiting with y at zero");

    // A step with no ellipse in progress is dropped, and the block is ready again in the next cycle.
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tuser && phase_reg != PH_REGION1 &&
         phase_reg != PH_REGION2)
        |=> (s_axis_tready && phase_reg == PH_IDLE))
        else $error("step while idle did not return to idle");

    // Between commands the slopes match 2*ry^2*x and 2*rx^2*y.
    a_slopes: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |->
        ((DEC_BITS'(y_slope_reg) ==
          DEC_BITS'(rx_sq_reg) * DEC_BITS'(cur_y_reg) * DEC_BITS'(2)) &&
         (DEC_BITS'(x_slope_reg) ==
          DEC_BITS'(ry_sq_reg) * DEC_BITS'(cur_x_reg) * DEC_BITS'(2))))
        else $error("slope registers out of step with x and y");
`endif

endmodule

### tb/tb_midpoint_ellipse_rasterizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer core testbench
// Drives start and step commands into the slave stream and checks every pixel
// on the master stream against an in-bench model of the two-region walk.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer_core;
    import mer_pkg::*;

    // Command codes carried on s_axis_tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Cycles the receiver holds off during the backpressure test.
    localparam int HOLD_CYCLES  = 300;
    // Cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    // Cycles allowed after the last pixel for anything stray to show up.
    localparam int SETTLE_CYCLES = 16;

    // One expected pixel on the master stream.
    typedef struct packed {
        logic [PIX_BITS-1:0]   px;
        logic [PIX_BITS-1:0]   py;
        logic [COLOR_BITS-1:0] ink;
        logic                  last;
        logic                  done;
    } pixel_t;

    // One row of the directed command list. Rows with typed set carry their
    // expected pixels directly: the top point of a start has x = 0, so all
    // four pixels share tx and split between ty_hi and ty_lo.
    typedef struct packed {
        logic                   op;
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] rx;
        logic [RADIUS_BITS-1:0] ry;
        logic [COLOR_BITS-1:0]  ink;
        logic                   typed;
        logic [2:0]             n_pix;
        logic [PIX_BITS-1:0]    tx;
        logic [PIX_BITS-1:0]    ty_hi;
        logic [PIX_BITS-1:0]    ty_lo;
        logic                   tdone;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [0:22] = '{
        // A step straight out of reset has nothing to walk and emits nothing.
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b1, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        // Degenerate ellipse: all four pixels on the centre, finished at once.
        '{OP_START, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b1, 3'd4, 14'd0, 14'd0, 14'd0, 1'b1},
        // The block went idle again, so this step is ignored.
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b1, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        // Largest centre and radii: the top row lands beyond the coordinate range.
        '{OP_START, 12'd4095, 12'd4095, 11'd2047, 11'd2047, 24'hFFFFFF,
          1'b1, 3'd4, 14'd4095, 14'd6142, 14'd2048, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        // A start in the middle of a walk drops it; the bottom row goes negative.
        '{OP_START, 12'd0, 12'd0, 11'd2047, 11'd2047, 24'h5A5A5A,
          1'b1, 3'd4, 14'd0, 14'd2047, -14'sd2047, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        // Zero horizontal radius: region two from the start, x still steps to one.
        '{OP_START, 12'd100, 12'd200, 11'd0, 11'd2, 24'hA5A5A5,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        // Flat ellipse: y reaches zero while still in region one (eighth step).
        '{OP_START, 12'd50, 12'd60, 11'd9, 11'd1, 24'h123456,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0},
        // The walk already finished, so this last step emits nothing.
        '{OP_STEP, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000,
          1'b0, 3'd0, 14'd0, 14'd0, 14'd0, 1'b0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    m_axis_tuser;

    midpoint_ellipse_rasterizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle rates in percent for each side, changed by the main sequence.
    int sender_gap_pct   = 9;
    int receiver_gap_pct = 52;
    // Set by the main sequence to ask for one long receiver hold-off.
    logic hold_request = 1'b0;
    int   hold_left    = 0;

    int mismatch_count = 0;

    // Pixels predicted but not yet seen on the master stream, oldest first.
    pixel_t pending_pixels[$];

    // ------------------------------------------------------------------------
    // Walk model. Its state mirrors the block: the phase, the current offset
    // from the centre, the decision term, both slopes and the squared radii,
    // plus the centre and colour saved from the last start.
    // ------------------------------------------------------------------------
    phase_t                   walk_phase = PH_IDLE;
    logic signed [X_BITS:0]   cur_x      = '0;
    logic signed [X_BITS:0]   cur_y      = '0;
    logic signed [DEC_BITS-1:0]   decision = '0;
    logic signed [SLOPE_BITS-1:0] x_slope  = '0;
    logic signed [SLOPE_BITS-1:0] y_slope  = '0;
    logic signed [SQ_BITS:0]  rx_sq      = '0;
    logic signed [SQ_BITS:0]  ry_sq      = '0;
    logic [COORD_BITS-1:0]    org_x      = '0;
    logic [COORD_BITS-1:0]    org_y      = '0;
    logic [COLOR_BITS-1:0]    ink_saved  = '0;
    // The four mirrored pixels of the latest emitting command.
    pixel_t                   walk_pixels [4];

    // Once the region-one slope test fails, the region-two decision term is
    // set up exactly in integers; the walk ends here if y is already zero.
    function automatic void close_region1();
        if (x_slope < y_slope) begin
            walk_phase = PH_REGION1;
            return;
        end
        decision = ry_sq * (cur_x * cur_x + cur_x)
                 + rx_sq * (cur_y - 1) * (cur_y - 1)
                 - ry_sq * rx_sq;
        walk_phase = (cur_y > 0) ? PH_REGION2 : PH_IDLE;
    endfunction

    // Advances the model by one accepted command and returns how many pixels
    // it produces (zero or four), leaving them in walk_pixels.
    function automatic int advance_walk(input logic op,
                                        input logic [S_TDATA_BITS-1:0] payload);
        logic signed [RADIUS_BITS:0] rad_x;
        logic signed [RADIUS_BITS:0] rad_y;
        logic                        emits;
        int                          k;
        emits = 1'b1;
        if (op == OP_START) begin
            rad_x     = {1'b0, payload[IN_RX_LSB +: RADIUS_BITS]};
            rad_y     = {1'b0, payload[IN_RY_LSB +: RADIUS_BITS]};
            org_x     = payload[IN_CX_LSB +: COORD_BITS];
            org_y     = payload[IN_CY_LSB +: COORD_BITS];
            ink_saved = payload[IN_COLOR_LSB +: COLOR_BITS];
            rx_sq     = rad_x * rad_x;
            ry_sq     = rad_y * rad_y;
            cur_x     = '0;
            cur_y     = rad_y;
            // round(rx^2 / 4) done as (rx^2 + 2) >> 2.
            decision  = ry_sq + ((rx_sq + 2) >>> 2) - rad_y * rx_sq;
            x_slope   = '0;
            y_slope   = 2 * rx_sq * rad_y;
            close_region1();
        end else if (walk_phase == PH_REGION1) begin
            x_slope = x_slope + 2 * ry_sq;
            cur_x   = cur_x + 1;
            if (decision < 0) begin
                decision = decision + ry_sq + x_slope;
            end else begin
                cur_y    = cur_y - 1;
                y_slope  = y_slope - 2 * rx_sq;
                decision = decision + ry_sq + x_slope - y_slope;
            end
            close_region1();
        end else if (walk_phase == PH_REGION2) begin
            cur_y   = cur_y - 1;
            y_slope = y_slope - 2 * rx_sq;
            if (decision > 0) begin
                decision = decision + rx_sq - y_slope;
            end else begin
                cur_x    = cur_x + 1;
                x_slope  = x_slope + 2 * ry_sq;
                decision = decision + rx_sq - y_slope + x_slope;
            end
            walk_phase = (cur_y > 0) ? PH_REGION2 : PH_IDLE;
        end else begin
            // A step with no walk in progress is dropped.
            walk_phase = PH_IDLE;
            emits      = 1'b0;
        end
        if (!emits) begin
            return 0;
        end
        // Mirror order: (+x,+y), (-x,+y), (+x,-y), (-x,-y).
        for (k = 0; k < 4; k++) begin
            walk_pixels[k].px   = (k == 1 || k == 3) ? ({2'b00, org_x} - cur_x)
                                                      : ({2'b00, org_x} + cur_x);
            walk_pixels[k].py   = (k >= 2) ? ({2'b00, org_y} - cur_y)
                                           : ({2'b00, org_y} + cur_y);
            walk_pixels[k].ink  = ink_saved;
            walk_pixels[k].last = (k == 3);
            walk_pixels[k].done = (k == 3) && (walk_phase == PH_IDLE);
        end
        return 4;
    endfunction

    function automatic void queue_walk_pixels(input int n_pix);
        int k;
        for (k = 0; k < n_pix; k++) begin
            pending_pixels.push_back(walk_pixels[k]);
        end
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < 100) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Every field random; the zero fill above the fields stays zero.
    function automatic logic [S_TDATA_BITS-1:0] random_payload();
        logic [95:0]             raw;
        logic [S_TDATA_BITS-1:0] payload;
        raw     = {$urandom, $urandom, $urandom};
        payload = '0;
        payload[IN_USED_BITS-1:0] = raw[IN_USED_BITS-1:0];
        return payload;
    endfunction

    // Radii are mostly small so that whole ellipses finish quickly; a few
    // span the full range so that every radius bit toggles.
    function automatic logic [RADIUS_BITS-1:0] pick_radius();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) begin
            return RADIUS_BITS'($urandom_range(12));
        end else if (roll < 95) begin
            return RADIUS_BITS'($urandom_range(60));
        end
        return RADIUS_BITS'($urandom_range((1 << RADIUS_BITS) - 1));
    endfunction

    // Offers one command, with random idle cycles ahead of it, and waits for
    // the transaction. tvalid is left high so that back-to-back commands do
    // not toggle it; the next call, if it idles first, or a drain lowers it.
    task automatic send_cmd(input logic op, input logic [S_TDATA_BITS-1:0] payload,
                            output int n_pix);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= payload;
        @(posedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
        end
        n_pix = advance_walk(op, payload);
    endtask

    // Stops offering commands until every predicted pixel has arrived, then
    // lets the block settle.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random traffic until `quota` pixel-producing commands have gone in.
    // Most traffic is a start followed by steps to the end of the ellipse;
    // some walks are cut short by the next start, and a few lone steps land
    // while the block is idle.
    task automatic run_random(input int quota);
        logic [S_TDATA_BITS-1:0] payload;
        int emitted;
        int n_pix;
        int step_budget;
        int steps_done;
        emitted = 0;
        while (emitted < quota) begin
            if ($urandom_range(99) < 8) begin
                send_cmd(OP_STEP, random_payload(), n_pix);
                queue_walk_pixels(n_pix);
                if (n_pix != 0) begin
                    emitted++;
                end
            end else begin
                payload = random_payload();
                payload[IN_RX_LSB +: RADIUS_BITS] = pick_radius();
                payload[IN_RY_LSB +: RADIUS_BITS] = pick_radius();
                send_cmd(OP_START, payload, n_pix);
                queue_walk_pixels(n_pix);
                emitted++;
                step_budget = ($urandom_range(99) < 80) ? 60 : $urandom_range(6);
                steps_done  = 0;
                while (walk_phase != PH_IDLE && steps_done < step_budget
                       && emitted < quota) begin
                    send_cmd(OP_STEP, random_payload(), n_pix);
                    queue_walk_pixels(n_pix);
                    emitted++;
                    steps_done++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random backpressure, plus one long hold-off on request. The
    // hold-off is counted here so the sender keeps offering commands and the
    // block backs up into its input.
    // ------------------------------------------------------------------------
    initial
    begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_gap_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel checker: each master transaction is matched against the oldest
    // prediction, field by field, including the zero fill of tdata.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                flag_mismatch($sformatf("pixel with none expected, tdata=%h",
                                        m_axis_tdata));
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[0 +: PIX_BITS] !== want.px) begin
                    flag_mismatch($sformatf("pixel_x got %0d expected %0d",
                        $signed(m_axis_tdata[0 +: PIX_BITS]), $signed(want.px)));
                end
                if (m_axis_tdata[PIX_BITS +: PIX_BITS] !== want.py) begin
                    flag_mismatch($sformatf("pixel_y got %0d expected %0d",
                        $signed(m_axis_tdata[PIX_BITS +: PIX_BITS]), $signed(want.py)));
                end
                if (m_axis_tdata[2*PIX_BITS +: COLOR_BITS] !== want.ink) begin
                    flag_mismatch($sformatf("pixel_color got %h expected %h",
                        m_axis_tdata[2*PIX_BITS +: COLOR_BITS], want.ink));
                end
                if (m_axis_tdata[OUT_USED_BITS +: M_PAD_BITS] !== '0) begin
                    flag_mismatch($sformatf("tdata fill bits not zero: %h",
                        m_axis_tdata[OUT_USED_BITS +: M_PAD_BITS]));
                end
                if (m_axis_tlast !== want.last) begin
                    flag_mismatch($sformatf("last_of_step got %b expected %b",
                        m_axis_tlast, want.last));
                end
                if (m_axis_tuser !== want.done) begin
                    flag_mismatch($sformatf("ellipse_done got %b expected %b",
                        m_axis_tuser, want.done));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a hang shows up as a long run of cycles with no transaction
    // on either stream. The longest legal quiet stretch is the receiver's
    // hold-off, well below the limit.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d pixels pending",
                     QUIET_LIMIT, pending_pixels.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        plan_row_t               row;
        pixel_t                  typed_pix;
        logic [S_TDATA_BITS-1:0] payload;
        int                      i;
        int                      k;
        int                      n_pix;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands, sender idling lightly and receiver heavily.
        sender_gap_pct   = 9;
        receiver_gap_pct = 52;
        for (i = 0; i < $size(DIRECTED_PLAN); i++) begin
            row     = DIRECTED_PLAN[i];
            payload = '0;
            payload[IN_CX_LSB +: COORD_BITS]    = row.cx;
            payload[IN_CY_LSB +: COORD_BITS]    = row.cy;
            payload[IN_RX_LSB +: RADIUS_BITS]   = row.rx;
            payload[IN_RY_LSB +: RADIUS_BITS]   = row.ry;
            payload[IN_COLOR_LSB +: COLOR_BITS] = row.ink;
            send_cmd(row.op, payload, n_pix);
            if (row.typed) begin
                // The model still tracks the walk; the pixels come from the row.
                for (k = 0; k < row.n_pix; k++) begin
                    typed_pix.px   = row.tx;
                    typed_pix.py   = (k >= 2) ? row.ty_lo : row.ty_hi;
                    typed_pix.ink  = row.ink;
                    typed_pix.last = (k == 3);
                    typed_pix.done = (k == 3) && row.tdone;
                    pending_pixels.push_back(typed_pix);
                end
            end else begin
                queue_walk_pixels(n_pix);
            end
        end
        drain_pixels();

        // Random phase one, with a long receiver hold-off in the middle while
        // the sender keeps going. The drain afterwards is the sender's pause.
        run_random(60);
        hold_request = 1'b1;
        run_random(20);
        run_random(60);
        drain_pixels();

        // Random phase two: sender idles heavily, receiver lightly.
        sender_gap_pct   = 52;
        receiver_gap_pct = 9;
        run_random(140);
        drain_pixels();

        // Random phase three: both sides at full rate.
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        run_random(140);
        drain_pixels();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
